@@ sv/phase_vocoder_bin_frequency_top_macros.svh @@
// assertion macros for the bin frequency block
// used by the top level; no other dependencies
`ifndef PHASE_VOCODER_BIN_FREQUENCY_TOP_MACROS_SVH
`define PHASE_VOCODER_BIN_FREQUENCY_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PVBF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`define PVBF_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define PVBF_NEVER(lbl, cond)
`define PVBF_IMPLY(lbl, ante, cons)
`endif
`endif

@@ sv/pvbf_pkg.sv @@
// shared types, register codes and the cordic angle table
// no dependencies
package pvbf_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEPS_PER_STAGE = 3;
  localparam int ITER_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

  localparam logic [1:0] CFG_PHASE_ADVANCE = 2'd0;
  localparam logic [1:0] CFG_OVERLAP = 2'd1;
  localparam logic [1:0] CFG_BIN_WIDTH = 2'd2;

  localparam logic [15:0] RESET_PHASE_ADVANCE = 16'd16384;
  localparam logic [15:0] RESET_OVERLAP = 16'd1024;
  localparam logic [23:0] RESET_BIN_WIDTH = 24'd2757;

  typedef struct packed {
    logic signed [23:0] bin_real;
    logic signed [23:0] bin_imag;
    logic [11:0] bin_index;
    logic channel_start;
  } item_t;

  typedef struct packed {
    logic [23:0] magnitude;
    logic signed [39:0] frequency;
  } result_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [11:0] bin;
    logic in_range;
    logic use_prev;
  } issue_t;

  typedef struct packed {
    logic [15:0] phase_advance;
    logic [15:0] overlap;
    logic [23:0] bin_width;
  } cfg_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/phase_vocoder_bin_frequency_top.sv @@
// one bin per cycle sustained while result credits remain and the phase store is not clearing
// items pass through the 18-stage back pipeline; a 32-entry result queue with credit
// counting holds issue once 32 results are outstanding, so a stalled consumer never overflows it
// reset: synchronous; after reset all DFT_SIZE_MAX/2+1 phase store entries
// (2049 by default) are cleared before items are processed
module phase_vocoder_bin_frequency_top #(
  parameter int DFT_SIZE_MAX = 4096,
  parameter int PHASE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pvbf_pkg::item_t   bin_item,
  input  logic              pop,
  output logic              empty,
  output pvbf_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int OUT_DEPTH = 32;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  pvbf_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_advance <= pvbf_pkg::RESET_PHASE_ADVANCE;
      cfg.overlap <= pvbf_pkg::RESET_OVERLAP;
      cfg.bin_width <= pvbf_pkg::RESET_BIN_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        pvbf_pkg::CFG_PHASE_ADVANCE: cfg.phase_advance <= cfg_data[15:0];
        pvbf_pkg::CFG_OVERLAP: cfg.overlap <= cfg_data[15:0];
        pvbf_pkg::CFG_BIN_WIDTH: cfg.bin_width <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  logic avail;
  logic issue_go;
  logic clearing;
  pvbf_pkg::issue_t issue;
  logic [CW-1:0] outstanding;
  logic pop_go;
  logic res_valid;
  pvbf_pkg::result_t res;
  logic out_full;

  assign pop_go = pop && !empty;
  assign issue_go = avail && !clearing && (outstanding < CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({issue_go, pop_go})
        2'b10: outstanding <= outstanding + 1'b1;
        2'b01: outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  pvbf_front #(
    .DFT_SIZE_MAX(DFT_SIZE_MAX)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(bin_item),
    .full(full),
    .take(issue_go),
    .avail(avail),
    .issue(issue)
  );

  pvbf_back #(
    .DFT_SIZE_MAX(DFT_SIZE_MAX),
    .PHASE_BITS(PHASE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .issue_valid(issue_go),
    .issue(issue),
    .cfg(cfg),
    .clearing(clearing),
    .res_valid(res_valid),
    .res(res)
  );

  pvbf_fifo #(
    .WIDTH($bits(pvbf_pkg::result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk(clk),
    .rst(rst),
    .wr(res_valid),
    .wdata(res),
    .full(out_full),
    .rd(pop),
    .rdata(result),
    .empty(empty)
  );

`include "phase_vocoder_bin_frequency_top_macros.svh"

  `PVBF_NEVER(a_out_overflow, res_valid && out_full)
  `PVBF_NEVER(a_issue_while_clearing, issue_go && clearing)
  `PVBF_IMPLY(a_idle_means_empty, outstanding == '0, empty)
  `PVBF_IMPLY(a_credit_bound, issue_go, outstanding < CW'(OUT_DEPTH))

endmodule

@@ sv/pvbf_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module pvbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2049
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pvbf_fifo.sv @@
// small register fifo, power of two depth
// no dependencies
module pvbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;
  logic do_wr;
  logic do_rd;

  assign full = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/pvbf_front.sv @@
// front end: input queue and per-bin classification
// depends on pvbf_pkg and pvbf_fifo
module pvbf_front #(
  parameter int DFT_SIZE_MAX = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pvbf_pkg::item_t  item,
  output logic             full,
  input  logic             take,
  output logic             avail,
  output pvbf_pkg::issue_t issue
);

  localparam int NUM_BINS = DFT_SIZE_MAX / 2 + 1;

  pvbf_pkg::item_t head;
  logic empty;

  pvbf_fifo #(
    .WIDTH($bits(pvbf_pkg::item_t)),
    .DEPTH(4)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr(push),
    .wdata(item),
    .full(full),
    .rd(take),
    .rdata(head),
    .empty(empty)
  );

  assign avail = !empty;

  always_comb begin
    issue.re = head.bin_real;
    issue.im = head.bin_imag;
    issue.bin = head.bin_index;
    issue.in_range = {20'd0, head.bin_index} < 32'(NUM_BINS);
    issue.use_prev = issue.in_range && !head.channel_start;
  end

endmodule

@@ sv/pvbf_back.sv @@
// back end: magnitude, cordic phase, per-bin phase store and frequency math
// depends on pvbf_pkg and pvbf_ram
module pvbf_back #(
  parameter int DFT_SIZE_MAX = 4096,
  parameter int PHASE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              issue_valid,
  input  pvbf_pkg::issue_t  issue,
  input  pvbf_pkg::cfg_t    cfg,
  output logic              clearing,
  output logic              res_valid,
  output pvbf_pkg::result_t res
);

  localparam int NUM_BINS = DFT_SIZE_MAX / 2 + 1;
  localparam int AW = $clog2(NUM_BINS);
  localparam int NS = 18;
  localparam int LAST_ITER = 2 + pvbf_pkg::ITER_STAGES;
  localparam logic [31:0] PH_ROUND = 32'd1 << (31 - PHASE_BITS);

  logic vld [1:NS];
  logic [11:0] bin [1:NS];
  logic rng [1:NS];
  logic usep [1:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[1] <= issue_valid;
      for (int k = 2; k <= NS; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    bin[1] <= issue.bin;
    rng[1] <= issue.in_range;
    usep[1] <= issue.use_prev;
    for (int k = 2; k <= NS; k++) begin
      bin[k] <= bin[k-1];
      rng[k] <= rng[k-1];
      usep[k] <= usep[k-1];
    end
  end

  // stage 1: fold into right half plane, squares, expected advance
  logic signed [24:0] xe, ye, xn, yn, ya;
  logic xneg;
  logic [27:0] adv_prod;
  logic signed [47:0] sq_re, sq_im;

  assign xe = 25'(issue.re);
  assign ye = 25'(issue.im);
  assign xneg = issue.re[23];
  assign xn = xneg ? -xe : xe;
  assign yn = xneg ? -ye : ye;
  assign ya = yn[24] ? -yn : yn;
  assign adv_prod = {16'd0, issue.bin} * {12'd0, cfg.phase_advance};
  assign sq_re = issue.re * issue.re;
  assign sq_im = issue.im * issue.im;

  logic signed [24:0] x1, y1;
  logic [23:0] m1;
  logic [31:0] z1;
  logic zero1;
  logic [46:0] sqr1, sqi1;
  logic [15:0] padv [1:12];

  always_ff @(posedge clk) begin
    x1 <= xn;
    y1 <= yn;
    m1 <= (xn[23:0] > ya[23:0]) ? xn[23:0] : ya[23:0];
    z1 <= xneg ? 32'h8000_0000 : 32'd0;
    zero1 <= (issue.re == '0) && (issue.im == '0);
    sqr1 <= sq_re[46:0];
    sqi1 <= sq_im[46:0];
    padv[1] <= adv_prod[15:0];
    for (int k = 2; k <= 12; k++) begin
      padv[k] <= padv[k-1];
    end
  end

  // stage 2: normalize, sum of squares
  logic [4:0] msb;
  logic [5:0] sh;

  always_comb begin
    msb = '0;
    for (int b = 0; b < 24; b++) begin
      if (m1[b]) begin
        msb = 5'(b);
      end
    end
    sh = 6'd30 - {1'b0, msb};
  end

  logic signed [34:0] cx [2:LAST_ITER];
  logic signed [34:0] cy [2:LAST_ITER];
  logic [31:0] cz [2:LAST_ITER];
  logic zf [2:LAST_ITER];
  logic [27:0] srem [2:LAST_ITER];
  logic [23:0] sroot [2:LAST_ITER];
  logic [47:0] sn [2:LAST_ITER];

  always_ff @(posedge clk) begin
    cx[2] <= 35'(x1) <<< sh;
    cy[2] <= 35'(y1) <<< sh;
    cz[2] <= z1;
    zf[2] <= zero1;
    srem[2] <= '0;
    sroot[2] <= '0;
    sn[2] <= {1'b0, sqr1} + {1'b0, sqi1};
  end

  // cordic and square root iterations, three steps per stage
  for (genvar j = 0; j < pvbf_pkg::ITER_STAGES; j++) begin : g_iter
    logic signed [34:0] xt, yt, xo;
    logic [31:0] zt;
    logic [27:0] rt;
    logic [23:0] qt;
    logic [47:0] nt;

    always_comb begin
      xt = cx[j+2];
      yt = cy[j+2];
      zt = cz[j+2];
      rt = srem[j+2];
      qt = sroot[j+2];
      nt = sn[j+2];
      xo = xt;
      for (int t = 0; t < pvbf_pkg::STEPS_PER_STAGE; t++) begin
        xo = xt;
        if (!yt[34]) begin
          xt = xt + (yt >>> (pvbf_pkg::STEPS_PER_STAGE * j + t));
          yt = yt - (xo >>> (pvbf_pkg::STEPS_PER_STAGE * j + t));
          zt = zt + pvbf_pkg::atan_turns(5'(pvbf_pkg::STEPS_PER_STAGE * j + t));
        end else begin
          xt = xt - (yt >>> (pvbf_pkg::STEPS_PER_STAGE * j + t));
          yt = yt + (xo >>> (pvbf_pkg::STEPS_PER_STAGE * j + t));
          zt = zt - pvbf_pkg::atan_turns(5'(pvbf_pkg::STEPS_PER_STAGE * j + t));
        end
        rt = {rt[25:0], nt[47:46]};
        nt = {nt[45:0], 2'b00};
        if (rt >= {2'b00, qt, 2'b01}) begin
          rt = rt - {2'b00, qt, 2'b01};
          qt = {qt[22:0], 1'b1};
        end else begin
          qt = {qt[22:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      cx[j+3] <= xt;
      cy[j+3] <= yt;
      cz[j+3] <= zt;
      zf[j+3] <= zf[j+2];
      srem[j+3] <= rt;
      sroot[j+3] <= qt;
      sn[j+3] <= nt;
    end
  end

  // stage 11: round phase; stage 12: phase store access
  logic [31:0] zr;
  logic [PHASE_BITS-1:0] ph [11:13];
  logic [23:0] mag [11:NS];

  assign zr = cz[LAST_ITER] + PH_ROUND;

  always_ff @(posedge clk) begin
    ph[11] <= zf[LAST_ITER] ? '0 : zr[31 -: PHASE_BITS];
    ph[12] <= ph[11];
    ph[13] <= ph[12];
    mag[11] <= sroot[LAST_ITER];
    for (int k = 12; k <= NS; k++) begin
      mag[k] <= mag[k-1];
    end
  end

  logic [AW-1:0] clr;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [PHASE_BITS-1:0] ram_wdata;
  logic [PHASE_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr <= '0;
    end else if (clearing) begin
      if (clr == AW'(NUM_BINS - 1)) begin
        clearing <= 1'b0;
      end
      clr <= clr + 1'b1;
    end
  end

  assign ram_we = clearing || (vld[12] && rng[12]);
  assign ram_waddr = clearing ? clr : AW'(bin[12]);
  assign ram_wdata = clearing ? '0 : ph[12];

  pvbf_ram #(
    .WIDTH(PHASE_BITS),
    .DEPTH(NUM_BINS)
  ) u_phase_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(bin[11])),
    .rdata(ram_rdata)
  );

  // bypass the store when the item just ahead wrote the same bin
  logic fwd;
  logic [PHASE_BITS-1:0] prev;
  logic [31:0] dev;

  assign fwd = vld[13] && rng[13] && (bin[13] == bin[12]);
  assign prev = usep[12] ? (fwd ? ph[13] : ram_rdata) : '0;
  assign dev = (32'(ph[12]) << (32 - PHASE_BITS)) - (32'(prev) << (32 - PHASE_BITS))
               - {padv[12], 16'd0};

  logic signed [31:0] w13;
  logic signed [48:0] d14;
  logic signed [48:0] d14r;
  logic signed [37:0] s15;
  logic [42:0] lo16;
  logic signed [43:0] hi16;
  logic signed [63:0] prod17;
  logic signed [63:0] prod_r;
  logic signed [39:0] f18;

  assign d14r = d14 + 49'sd32768;
  assign prod_r = prod17 + 64'sd8388608;

  // product stays within 2^61, so the result always fits 40 bits
  always_ff @(posedge clk) begin
    w13 <= dev;
    d14 <= w13 * $signed({1'b0, cfg.overlap});
    s15 <= $signed({2'b00, bin[14], 24'd0}) + 38'(d14r >>> 16);
    lo16 <= {24'd0, s15[18:0]} * {19'd0, cfg.bin_width};
    hi16 <= $signed(s15[37:19]) * $signed({1'b0, cfg.bin_width});
    prod17 <= (64'(hi16) <<< 19) + $signed({21'd0, lo16});
    f18 <= 40'(prod_r >>> 24);
  end

  assign res_valid = vld[NS];
  assign res.magnitude = mag[NS];
  assign res.frequency = f18;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for phase_vocoder_bin_frequency_top: directed table, then random
// frames checked against an in-bench bin frequency predictor; depends on pvbf_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS = 2049;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  pvbf_pkg::item_t bin_item = '0;
  logic pop = 1'b0;
  logic empty;
  pvbf_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pvbf_pkg::CFG_PHASE_ADVANCE;
  logic [23:0] cfg_data = '0;

  phase_vocoder_bin_frequency_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .bin_item(bin_item),
    .pop(pop), .empty(empty), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    pvbf_pkg::item_t it;
    bit typed;
    pvbf_pkg::result_t want;
  } stim_row_t;

  logic [31:0] arc_turns [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  logic [15:0] last_phase [0:NUM_BINS-1];
  logic [15:0] adv_reg = pvbf_pkg::RESET_PHASE_ADVANCE;
  logic [15:0] ovl_reg = pvbf_pkg::RESET_OVERLAP;
  logic [23:0] bw_reg = pvbf_pkg::RESET_BIN_WIDTH;

  pvbf_pkg::result_t pending_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  int quiet = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] angle_turns(longint x, longint y);
    logic [31:0] z;
    longint ax, ay, m, xo;
    bit yneg;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    yneg = y < 0;
    ax = x;
    ay = yneg ? -y : y;
    m = ax > ay ? ax : ay;
    while (m < (64'sd1 <<< 30)) begin
      m = m <<< 1;
      ax = ax <<< 1;
      ay = ay <<< 1;
    end
    x = ax;
    y = yneg ? -ay : ay;
    for (int i = 0; i < 24; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        z = z + arc_turns[i];
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        z = z - arc_turns[i];
      end
    end
    return z;
  endfunction

  function automatic pvbf_pkg::result_t predict_bin(pvbf_pkg::item_t it);
    pvbf_pkg::result_t r;
    longint re, im, w, dev40, s24, prod, f;
    logic [31:0] z, rounded, dev, adv_prod;
    logic [15:0] ph, prev;
    longint unsigned bin;
    re = it.bin_real;
    im = it.bin_imag;
    bin = it.bin_index;
    r.magnitude = 24'(int_sqrt(longint'(re * re) + longint'(im * im)));
    z = angle_turns(re, im);
    rounded = z + 32'd32768;
    ph = rounded[31:16];
    prev = '0;
    if (bin < NUM_BINS) begin
      if (!it.channel_start) prev = last_phase[bin];
      last_phase[bin] = ph;
    end
    adv_prod = 32'(bin * adv_reg);
    dev = {ph, 16'd0} - {prev, 16'd0} - {adv_prod[15:0], 16'd0};
    w = longint'(signed'(dev));
    dev40 = w * longint'(ovl_reg);
    s24 = (longint'(bin) <<< 24) + ((dev40 + (64'sd1 <<< 15)) >>> 16);
    prod = s24 * longint'(bw_reg);
    f = (prod + (64'sd1 <<< 23)) >>> 24;
    if (f > 64'sd549755813887) f = 64'sd549755813887;
    if (f < -64'sd549755813888) f = -64'sd549755813888;
    r.frequency = f[39:0];
    return r;
  endfunction

  task automatic send_bin(pvbf_pkg::item_t it, bit typed, pvbf_pkg::result_t want);
    pvbf_pkg::result_t r;
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    bin_item = it;
    do @(posedge clk); while (full);
    r = predict_bin(it);
    pending_results.push_back(typed ? want : r);
    beats_in++;
    @(negedge clk);
    push = 1'b0;
    bin_item.bin_real = 24'($urandom);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pvbf_pkg::CFG_PHASE_ADVANCE: adv_reg = val[15:0];
      pvbf_pkg::CFG_OVERLAP: ovl_reg = val[15:0];
      pvbf_pkg::CFG_BIN_WIDTH: bw_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_part();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'(signed'(24'($urandom_range(255))) - 24'sd128);
      2: return 24'($urandom) >>> $urandom_range(23);
      default: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  task automatic random_traffic(int count);
    pvbf_pkg::item_t it;
    int sent, top;
    bit first;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        top = $urandom_range(1) ? $urandom_range(16) : $urandom_range(2048);
        if (top > 40 && $urandom_range(3) != 0) top = 40;
        first = $urandom_range(3) == 0;
        for (int b = 0; b <= top && sent < count; b++) begin
          it.bin_real = rand_part();
          it.bin_imag = rand_part();
          it.bin_index = 12'(b);
          it.channel_start = first;
          send_bin(it, 1'b0, '0);
          sent++;
        end
      end else begin
        it.bin_real = rand_part();
        it.bin_imag = rand_part();
        it.bin_index = 12'($urandom_range(4095));
        it.channel_start = 1'($urandom_range(1));
        send_bin(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) pop <= !hold_off && ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    pvbf_pkg::result_t want;
    if (!rst && pop && !empty) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual mag %0d freq %0d", $time,
                 result.magnitude, result.frequency);
      end else begin
        want = pending_results.pop_front();
        if (result.magnitude !== want.magnitude) begin
          errors++;
          $display("%0t: magnitude expected %0d actual %0d", $time,
                   want.magnitude, result.magnitude);
        end
        if (result.frequency !== want.frequency) begin
          errors++;
          $display("%0t: frequency expected %0d actual %0d", $time,
                   want.frequency, result.frequency);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic hold_receiver(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(negedge clk);
    hold_off = 1'b0;
  endtask

  stim_row_t rows [$];

  function automatic stim_row_t row(logic [23:0] re, logic [23:0] im, logic [11:0] bin,
                                    bit start, bit typed, logic [23:0] mag,
                                    logic [39:0] freq);
    stim_row_t s;
    s.it.bin_real = re;
    s.it.bin_imag = im;
    s.it.bin_index = bin;
    s.it.channel_start = start;
    s.typed = typed;
    s.want.magnitude = mag;
    s.want.frequency = freq;
    return s;
  endfunction

  initial begin
    for (int i = 0; i < NUM_BINS; i++) last_phase[i] = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // zero bin, extremes, bins at and past the store, channel start
    rows.push_back(row(24'd0, 24'd0, 12'd0, 1'b1, 1'b1, 24'd0, 40'd0));
    rows.push_back(row(24'h7fffff, 24'd0, 12'd0, 1'b0, 1'b1, 24'd8388607, 40'd0));
    rows.push_back(row(24'h800000, 24'd0, 12'd0, 1'b1, 1'b1, 24'd8388608, -40'sd5514));
    rows.push_back(row(24'd0, 24'h7fffff, 12'd1, 1'b1, 1'b0, '0, '0));
    rows.push_back(row(24'd0, 24'h800000, 12'd1, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'h800000, 24'h800000, 12'd2, 1'b0, 1'b1, 24'd11863283, '0));
    rows.push_back(row(24'h7fffff, 24'h7fffff, 12'd2048, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'h7fffff, 24'h800000, 12'd2048, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'd5, 24'd7, 12'd2049, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'd5, 24'hfffff9, 12'd4095, 1'b1, 1'b0, '0, '0));
    rows.push_back(row(24'hffffff, 24'd1, 12'd3, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'hffffff, 24'd1, 12'd3, 1'b0, 1'b0, '0, '0));
    rows.push_back(row(24'd1, 24'd0, 12'd3, 1'b1, 1'b0, '0, '0));
    rows.push_back(row(24'h123456, 24'hedcba9, 12'd2047, 1'b0, 1'b0, '0, '0));
    rows[5].typed = 1'b0;

    send_idle = 16;
    recv_idle = 67;
    foreach (rows[i]) send_bin(rows[i].it, rows[i].typed, rows[i].want);
    fork
      hold_receiver(300);
    join_none
    random_traffic(100);
    drain();

    write_reg(pvbf_pkg::CFG_PHASE_ADVANCE, 24'd65535);
    write_reg(pvbf_pkg::CFG_OVERLAP, 24'd65535);
    write_reg(pvbf_pkg::CFG_BIN_WIDTH, 24'hffffff);
    send_idle = 67;
    recv_idle = 16;
    random_traffic(100);
    drain();

    write_reg(pvbf_pkg::CFG_PHASE_ADVANCE, 24'd0);
    write_reg(pvbf_pkg::CFG_OVERLAP, 24'd0);
    write_reg(pvbf_pkg::CFG_BIN_WIDTH, 24'd0);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(40);
    drain();
    write_reg(pvbf_pkg::CFG_OVERLAP, 24'd256);
    write_reg(pvbf_pkg::CFG_BIN_WIDTH, 24'd1);
    random_traffic(40);
    drain();

    write_reg(pvbf_pkg::CFG_PHASE_ADVANCE, 24'($urandom_range(65535)));
    write_reg(pvbf_pkg::CFG_OVERLAP, 24'($urandom_range(65535, 256)));
    write_reg(pvbf_pkg::CFG_BIN_WIDTH, 24'($urandom_range(16777215, 1)));
    random_traffic(120);
    drain();

    $display("tb: %0d bins in, %0d results out, over five register settings", beats_in,
             beats_out);
    $display("tb: with idle and stall mixes, a long receiver hold and out-of-store bins");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
